@@ rtl/core/decimal_to_fixed_point_accumulator_defines.svh @@
// ----------------------------------------------------------------------------
// Decimal to fixed point accumulator - assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_TO_FIXED_POINT_ACCUMULATOR_DEFINES_SVH
`define DECIMAL_TO_FIXED_POINT_ACCUMULATOR_DEFINES_SVH

// consequent checked in the same cycle
`define DTFA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define DTFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/dtfa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal to fixed point accumulator - package
// Transaction types and conversion constants.
// ----------------------------------------------------------------------------
package dtfa_pkg;

    localparam int FracBits  = 14;
    localparam int Steps     = 14;
    localparam int HalfSteps = Steps / 2;
    localparam int IntW      = 17;
    localparam int DigitsW   = 14;
    localparam int CompStart = 5000000;
    localparam int DecScale  = 1000;
    localparam int RemW      = 24;
    localparam int FixedW    = 32;
    localparam int TotalW    = 64;
    localparam int PipeDepth = 4;

    typedef struct packed {
        logic               negative;
        logic [IntW-1:0]    integer_part;
        logic [DigitsW-1:0] fraction_digits;
    } number_t;

    typedef struct packed {
        logic signed [FixedW-1:0] fixed_value;
        logic signed [TotalW-1:0] running_total;
    } result_t;

endpackage

@@ rtl/core/dtfa_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal to fixed point accumulator - stream interface
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface dtfa_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/decimal_to_fixed_point_accumulator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal to fixed point accumulator
// Throughput: one transaction per cycle unless result.ready stalls the output;
// four stages (input, fraction high half, fraction low half with sign,
// accumulate) each hold one item, and a result leaves from the accumulate stage.
// Reset: asynchronous, active low; empties the pipeline, zeroes the total.
// ----------------------------------------------------------------------------
module decimal_to_fixed_point_accumulator (
    input  logic          clk,
    input  logic          rst_n,
    dtfa_stream_if.sink   number,
    dtfa_stream_if.source result
);
    import dtfa_pkg::*;

    // stage 1: captured number, fraction scaled by 1000
    logic                s1_valid_reg;
    logic                s1_neg_reg;
    logic [IntW-1:0]     s1_ipart_reg;
    logic [RemW-1:0]     s1_rem_reg;
    // stage 2: upper fraction bits resolved
    logic                s2_valid_reg;
    logic                s2_neg_reg;
    logic [IntW-1:0]     s2_ipart_reg;
    logic [HalfSteps-1:0] s2_bits_reg;
    logic [RemW-1:0]     s2_rem_reg;
    // stage 3: signed fixed point value
    logic                s3_valid_reg;
    logic [FixedW-1:0]   s3_fixed_reg;
    // output stage
    logic                out_valid_reg;
    logic [FixedW-1:0]   out_fixed_reg;
    logic [TotalW-1:0]   total_reg;
    logic [TotalW-1:0]   total_next;

    logic                 out_free;
    logic                 s3_free;
    logic                 s2_free;
    logic                 s1_free;
    logic [RemW-1:0]      rem_in;
    logic [RemW-1:0]      rem_a;
    logic [HalfSteps-1:0] bits_a;
    logic [RemW-1:0]      rem_b;
    logic [HalfSteps-1:0] bits_b;
    logic [FixedW-1:0]    mag;
    logic [FixedW-1:0]    fixed_next;

    assign out_free = !out_valid_reg || result.ready;
    assign s3_free  = !s3_valid_reg || out_free;
    assign s2_free  = !s2_valid_reg || s3_free;
    assign s1_free  = !s1_valid_reg || s2_free;

    assign number.ready = s1_free;

    assign rem_in = RemW'(number.payload.fraction_digits) * RemW'(DecScale);

    always_comb
    begin
        rem_a  = s1_rem_reg;
        bits_a = '0;
        for (int i = 0; i < HalfSteps; i++)
        begin
            if (rem_a >= RemW'(CompStart >> i))
            begin
                rem_a                  = rem_a - RemW'(CompStart >> i);
                bits_a[HalfSteps-1-i]  = 1'b1;
            end
        end
    end

    always_comb
    begin
        rem_b  = s2_rem_reg;
        bits_b = '0;
        for (int i = 0; i < HalfSteps; i++)
        begin
            if (rem_b >= RemW'(CompStart >> (i + HalfSteps)))
            begin
                rem_b                  = rem_b - RemW'(CompStart >> (i + HalfSteps));
                bits_b[HalfSteps-1-i]  = 1'b1;
            end
        end
    end

    always_comb
    begin
        mag = {1'b0, s2_ipart_reg, s2_bits_reg, bits_b};
        // leftover remainder marks an inexact fraction in the LSB
        if (!mag[0] && (rem_b != '0))
        begin
            mag[0] = 1'b1;
        end
        fixed_next = s2_neg_reg ? (~mag + FixedW'(1)) : mag;
    end

    assign total_next = total_reg + {{(TotalW-FixedW){s3_fixed_reg[FixedW-1]}}, s3_fixed_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= number.valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_free)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s3_valid_reg;
                if (s3_valid_reg)
                begin
                    total_reg <= total_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free && number.valid)
        begin
            s1_neg_reg   <= number.payload.negative;
            s1_ipart_reg <= number.payload.integer_part;
            s1_rem_reg   <= rem_in;
        end
        if (s2_free && s1_valid_reg)
        begin
            s2_neg_reg   <= s1_neg_reg;
            s2_ipart_reg <= s1_ipart_reg;
            s2_bits_reg  <= bits_a;
            s2_rem_reg   <= rem_a;
        end
        if (s3_free && s2_valid_reg)
        begin
            s3_fixed_reg <= fixed_next;
        end
        if (out_free && s3_valid_reg)
        begin
            out_fixed_reg <= s3_fixed_reg;
        end
    end

    assign result.valid                 = out_valid_reg;
    assign result.payload.fixed_value   = out_fixed_reg;
    assign result.payload.running_total = total_reg;

endmodule

@@ rtl/core/dtfa_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal to fixed point accumulator - port checker
// Watches the top level ports: output hold, running total consistency and
// transaction bookkeeping.
// ----------------------------------------------------------------------------
`include "decimal_to_fixed_point_accumulator_defines.svh"

module dtfa_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              number_valid,
    input logic              number_ready,
    input logic              result_valid,
    input logic              result_ready,
    input dtfa_pkg::result_t result_payload
);
    import dtfa_pkg::*;

    logic              in_acc;
    logic              out_acc;
    logic [2:0]        outstanding_reg;
    logic [2:0]        outstanding_next;
    logic [TotalW-1:0] last_total_reg;
    logic [TotalW-1:0] expected_total;

    assign in_acc  = number_valid && number_ready;
    assign out_acc = result_valid && result_ready;

    assign outstanding_next = outstanding_reg + {2'b0, in_acc} - {2'b0, out_acc};
    assign expected_total   = last_total_reg
        + {{(TotalW-FixedW){result_payload.fixed_value[FixedW-1]}},
           result_payload.fixed_value};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
            last_total_reg  <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
            if (out_acc)
            begin
                last_total_reg <= result_payload.running_total;
            end
        end
    end

    `DTFA_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready,
        result_valid && $stable(result_payload), "stalled result changed")
    `DTFA_ASSERT_SAME(a_total_sum, clk, rst_n, out_acc,
        result_payload.running_total == expected_total, "running total mismatch")
    `DTFA_ASSERT_SAME(a_no_spurious, clk, rst_n, result_valid,
        outstanding_reg != 3'd0, "result without a pending number")
    `DTFA_ASSERT_SAME(a_capacity, clk, rst_n, 1'b1,
        outstanding_reg <= 3'(PipeDepth), "more transactions in flight than stages")

endmodule

bind decimal_to_fixed_point_accumulator dtfa_checker u_dtfa_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .number_valid   (number.valid),
    .number_ready   (number.ready),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .result_payload (result.payload)
);
